// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the ARQ sender RTL
// Same-cycle and next-cycle implications on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAWARQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SAWARQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sawarq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawarq_pkg
// Types, constants and helpers of the stop-and-wait ARQ sender.
// ----------------------------------------------------------------------------
package sawarq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_BYTES = 20;

  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int BIDX_W    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int SCNT_W    = $clog2(PAYLOAD_BYTES + 1);
  localparam int PAY_DEPTH = QUEUE_DEPTH * PAYLOAD_BYTES;
  localparam int PAY_AW    = $clog2(PAY_DEPTH);
  localparam int SEQ_W     = 16;
  localparam int TMR_W     = 16;
  localparam int CSUM_W    = 32;
  localparam int BYTE_W    = 8;

  localparam logic [TMR_W-1:0]  TIMEOUT_RESET = TMR_W'(10);
  localparam logic [BIDX_W-1:0] LAST_IDX      = BIDX_W'(PAYLOAD_BYTES - 1);

  typedef enum logic [1:0] {
    CMD_MSG_BYTE = 2'd0,
    CMD_ACK_HDR  = 2'd1,
    CMD_ACK_BYTE = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_ACKED = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [BYTE_W-1:0] data_byte;
    logic                     byte_last;
    logic [SEQ_W-1:0]         ack_seq;
    logic [15:0]              ack_flag_field;
    logic signed [CSUM_W-1:0] ack_checksum;
  } in_word_t;

  typedef struct packed {
    kind_t                    out_kind;
    logic [SEQ_W-1:0]         out_seq;
    logic                     out_ack_field;
    logic signed [CSUM_W-1:0] out_checksum;
    logic signed [BYTE_W-1:0] out_byte;
    logic                     out_last;
    logic                     out_retransmit;
  } out_word_t;

  // Verdict of the ack checker for the payload byte in hand.
  typedef struct packed {
    logic             done;
    logic             csum_ok;
    logic [SEQ_W-1:0] seq;
  } ack_status_t;

  function automatic logic [CSUM_W-1:0] sext8(input logic [BYTE_W-1:0] b);
    return {{(CSUM_W - BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

  function automatic logic [PAY_AW-1:0] pay_addr(input logic [QPTR_W-1:0] slot,
                                                 input logic [BIDX_W-1:0] idx);
    logic [PAY_AW-1:0] base;
    base = PAY_AW'(slot) * PAY_AW'(PAYLOAD_BYTES);
    return base + PAY_AW'(idx);
  endfunction

  function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] s);
    return (s == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : s + QPTR_W'(1);
  endfunction

endpackage

// File: rtl/sawarq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawarq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sawarq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sawarq_ack_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawarq_ack_chk
// Latches the ack header and accumulates the ack payload checksum.
// ----------------------------------------------------------------------------
module sawarq_ack_chk (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    hdr_we,
  input  logic                    byte_we,
  input  sawarq_pkg::in_word_t    in_word,
  output sawarq_pkg::ack_status_t status
);
  import sawarq_pkg::*;

  logic [SEQ_W-1:0]  seq_r;
  logic              flag_one_r;
  logic [CSUM_W-1:0] pre_r;
  logic [CSUM_W-1:0] csum_r;
  logic [CSUM_W-1:0] sum_r;
  logic [BIDX_W-1:0] idx_r;
  logic [CSUM_W-1:0] sum_nxt;
  logic              done;

  assign sum_nxt = sum_r + sext8(in_word.data_byte);
  assign done    = in_word.byte_last || (idx_r >= LAST_IDX);

  assign status.done    = done;
  assign status.csum_ok = flag_one_r && ((pre_r + sum_nxt) == csum_r);
  assign status.seq     = seq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= '0;
      flag_one_r <= 1'b0;
      pre_r      <= '0;
      csum_r     <= '0;
      sum_r      <= '0;
      idx_r      <= '0;
    end else if (hdr_we) begin
      // pre-add seq and ack field so the verdict needs one add and compare
      seq_r      <= in_word.ack_seq;
      flag_one_r <= (in_word.ack_flag_field == 16'd1);
      pre_r      <= CSUM_W'(in_word.ack_seq) + CSUM_W'(in_word.ack_flag_field);
      csum_r     <= in_word.ack_checksum;
      sum_r      <= '0;
      idx_r      <= '0;
    end else if (byte_we) begin
      if (done) begin
        sum_r <= '0;
        idx_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        idx_r <= idx_r + BIDX_W'(1);
      end
    end
  end

endmodule

// File: rtl/stop_and_wait_arq_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender
// Sender of a stop-and-wait ARQ: packet queue, checksum, ack check, timer.
// ----------------------------------------------------------------------------
// Input words carry message bytes, ack headers, ack payload bytes or timer
// ticks; output words are packet bytes, timer-stopped notices or drop flags.
// Both channels use valid/stall; cfg_we writes the retransmit timeout.
// A message that ends early zero-fills the rest of its slot. A packet send
// streams the stored bytes out of the payload RAM through its registered
// read port, one byte a cycle while the receiver does not stall. No input
// is taken during a fill or a send. A receiver stall holds the output word
// and pauses the send; input is also held off while a result waits to leave.
// After reset the queue is empty, nothing is outstanding, the sequence is
// zero and the timeout is 10 ticks. The payload and checksum RAMs are not
// cleared: every slot is written in full before it is sent.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sawarq_pkg::in_word_t     in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sawarq_pkg::out_word_t    out_word,
  input  logic                     cfg_we,
  input  logic [sawarq_pkg::TMR_W-1:0] cfg_wdata
);
  import sawarq_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_SEND
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;
  logic [TMR_W-1:0]  timeout_r;
  logic [QPTR_W-1:0] q_head_r, q_head_nxt;
  logic [QPTR_W-1:0] q_tail_r, q_tail_nxt;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic [SEQ_W-1:0]  next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]  head_seq_r, head_seq_nxt;
  logic              outstanding_r, outstanding_nxt;
  logic [TMR_W-1:0]  timer_r, timer_nxt;
  logic [BIDX_W-1:0] b_idx_r, b_idx_nxt;
  logic [CSUM_W-1:0] b_sum_r, b_sum_nxt;
  logic              b_drop_r, b_drop_nxt;
  logic [QPTR_W-1:0] fill_slot_r, fill_slot_nxt;
  logic [BIDX_W-1:0] fill_idx_r, fill_idx_nxt;
  logic              fill_send_r, fill_send_nxt;
  logic [SCNT_W-1:0] s_idx_r, s_idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              retx_r, retx_nxt;

  logic              out_free;
  logic              in_acc;
  logic              drop_now;
  logic              msg_done;
  logic [CSUM_W-1:0] msg_sum;
  logic [QCNT_W-1:0] cnt_after_ack;
  logic              ack_ok;
  logic              send_load;
  logic              send_issue;
  logic              start_send;
  logic              start_retx;
  ack_status_t       ack_st;

  logic              pay_we, pay_re;
  logic [PAY_AW-1:0] pay_waddr, pay_raddr;
  logic [BYTE_W-1:0] pay_wdata, pay_rdata;
  logic              ck_we, ck_re;
  logic [CSUM_W-1:0] ck_wdata, ck_rdata;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // message build: the full-queue decision is taken at the first byte
  assign drop_now = (b_idx_r == '0) ? (q_cnt_r >= QCNT_W'(QUEUE_DEPTH)) : b_drop_r;
  assign msg_sum  = ((b_idx_r == '0) ? '0 : b_sum_r) + sext8(in_word.data_byte);
  assign msg_done = in_word.byte_last || (b_idx_r >= LAST_IDX);
  assign ck_wdata = CSUM_W'(next_seq_r) + CSUM_W'(1) + msg_sum;

  assign cnt_after_ack = (q_cnt_r != '0) ? q_cnt_r - QCNT_W'(1) : q_cnt_r;
  assign ack_ok = ack_st.done && ack_st.csum_ok && outstanding_r
                  && (ack_st.seq == head_seq_r);

  // send stream: one read in flight, refilled as the output register drains
  assign send_load  = (state_r == S_SEND) && rd_pend_r && out_free;
  assign send_issue = (state_r == S_SEND) && (s_idx_r < SCNT_W'(PAYLOAD_BYTES))
                      && (!rd_pend_r || send_load);

  sawarq_ack_chk u_ack_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .hdr_we  (in_acc && (in_word.cmd == CMD_ACK_HDR)),
    .byte_we (in_acc && (in_word.cmd == CMD_ACK_BYTE)),
    .in_word (in_word),
    .status  (ack_st)
  );

  sawarq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAY_DEPTH)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  sawarq_ram #(
    .WIDTH (CSUM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ck_ram (
    .clk   (clk),
    .we    (ck_we),
    .waddr (q_tail_r),
    .wdata (ck_wdata),
    .re    (ck_re),
    .raddr (q_head_r),
    .rdata (ck_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_word_nxt    = out_word_r;
    q_head_nxt      = q_head_r;
    q_tail_nxt      = q_tail_r;
    q_cnt_nxt       = q_cnt_r;
    next_seq_nxt    = next_seq_r;
    head_seq_nxt    = head_seq_r;
    outstanding_nxt = outstanding_r;
    timer_nxt       = timer_r;
    b_idx_nxt       = b_idx_r;
    b_sum_nxt       = b_sum_r;
    b_drop_nxt      = b_drop_r;
    fill_slot_nxt   = fill_slot_r;
    fill_idx_nxt    = fill_idx_r;
    fill_send_nxt   = fill_send_r;
    s_idx_nxt       = s_idx_r;
    rd_pend_nxt     = rd_pend_r;
    retx_nxt        = retx_r;
    start_send      = 1'b0;
    start_retx      = 1'b0;
    pay_we          = 1'b0;
    pay_waddr       = pay_addr(q_tail_r, b_idx_r);
    pay_wdata       = in_word.data_byte;
    pay_re          = send_issue;
    pay_raddr       = pay_addr(q_head_r, s_idx_r[BIDX_W-1:0]);
    ck_we           = 1'b0;
    ck_re           = send_issue && (s_idx_r == '0);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_word.cmd)
            CMD_MSG_BYTE: begin
              pay_we = !drop_now;
              if (!msg_done) begin
                b_idx_nxt  = b_idx_r + BIDX_W'(1);
                b_sum_nxt  = msg_sum;
                b_drop_nxt = drop_now;
              end else begin
                b_idx_nxt  = '0;
                b_sum_nxt  = '0;
                b_drop_nxt = 1'b0;
                if (drop_now) begin
                  out_valid_nxt         = 1'b1;
                  out_word_nxt          = '0;
                  out_word_nxt.out_kind = KIND_DROP;
                  out_word_nxt.out_seq  = next_seq_r;
                end else begin
                  ck_we        = 1'b1;
                  q_tail_nxt   = next_slot(q_tail_r);
                  q_cnt_nxt    = q_cnt_r + QCNT_W'(1);
                  next_seq_nxt = next_seq_r + SEQ_W'(1);
                  if (b_idx_r != LAST_IDX) begin
                    // short message: zero the rest of the slot first
                    state_nxt     = S_FILL;
                    fill_slot_nxt = q_tail_r;
                    fill_idx_nxt  = b_idx_r + BIDX_W'(1);
                    fill_send_nxt = !outstanding_r;
                  end else if (!outstanding_r) begin
                    start_send = 1'b1;
                  end
                end
              end
            end
            CMD_ACK_HDR: begin
            end
            CMD_ACK_BYTE: begin
              if (ack_ok) begin
                outstanding_nxt = 1'b0;
                timer_nxt       = '0;
                q_head_nxt      = next_slot(q_head_r);
                q_cnt_nxt       = cnt_after_ack;
                head_seq_nxt    = head_seq_r + SEQ_W'(1);
                if (cnt_after_ack != '0) begin
                  start_send = 1'b1;
                end else begin
                  out_valid_nxt         = 1'b1;
                  out_word_nxt          = '0;
                  out_word_nxt.out_kind = KIND_ACKED;
                  out_word_nxt.out_seq  = ack_st.seq;
                end
              end
            end
            CMD_TICK: begin
              if (outstanding_r) begin
                if (timer_r > TMR_W'(1)) begin
                  timer_nxt = timer_r - TMR_W'(1);
                end else begin
                  start_send = 1'b1;
                  start_retx = 1'b1;
                end
              end
            end
          endcase
        end
      end
      S_FILL: begin
        pay_we    = 1'b1;
        pay_waddr = pay_addr(fill_slot_r, fill_idx_r);
        pay_wdata = '0;
        if (fill_idx_r == LAST_IDX) begin
          state_nxt  = S_IDLE;
          start_send = fill_send_r;
        end else begin
          fill_idx_nxt = fill_idx_r + BIDX_W'(1);
        end
      end
      S_SEND: begin
        if (send_load) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.out_kind       = KIND_SEND;
          out_word_nxt.out_seq        = head_seq_r;
          out_word_nxt.out_ack_field  = 1'b1;
          out_word_nxt.out_checksum   = ck_rdata;
          out_word_nxt.out_byte       = pay_rdata;
          out_word_nxt.out_last       = (s_idx_r == SCNT_W'(PAYLOAD_BYTES));
          out_word_nxt.out_retransmit = retx_r;
          if (s_idx_r == SCNT_W'(PAYLOAD_BYTES)) begin
            state_nxt = S_IDLE;
          end
        end
        if (send_issue) begin
          s_idx_nxt   = s_idx_r + SCNT_W'(1);
          rd_pend_nxt = 1'b1;
        end else if (send_load) begin
          rd_pend_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // start a send of the queue head and arm the timer
    if (start_send) begin
      state_nxt       = S_SEND;
      s_idx_nxt       = '0;
      rd_pend_nxt     = 1'b0;
      retx_nxt        = start_retx;
      outstanding_nxt = 1'b1;
      timer_nxt       = timeout_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      timeout_r     <= TIMEOUT_RESET;
      q_head_r      <= '0;
      q_tail_r      <= '0;
      q_cnt_r       <= '0;
      next_seq_r    <= '0;
      head_seq_r    <= '0;
      outstanding_r <= 1'b0;
      timer_r       <= '0;
      b_idx_r       <= '0;
      b_sum_r       <= '0;
      b_drop_r      <= 1'b0;
      fill_send_r   <= 1'b0;
      s_idx_r       <= '0;
      rd_pend_r     <= 1'b0;
      retx_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      q_head_r      <= q_head_nxt;
      q_tail_r      <= q_tail_nxt;
      q_cnt_r       <= q_cnt_nxt;
      next_seq_r    <= next_seq_nxt;
      head_seq_r    <= head_seq_nxt;
      outstanding_r <= outstanding_nxt;
      timer_r       <= timer_nxt;
      b_idx_r       <= b_idx_nxt;
      b_sum_r       <= b_sum_nxt;
      b_drop_r      <= b_drop_nxt;
      fill_send_r   <= fill_send_nxt;
      s_idx_r       <= s_idx_nxt;
      rd_pend_r     <= rd_pend_nxt;
      retx_r        <= retx_nxt;
    end
    out_word_r  <= out_word_nxt;
    fill_slot_r <= fill_slot_nxt;
    fill_idx_r  <= fill_idx_nxt;
  end

  `SAWARQ_ASSERT_NOW(a_cnt_bound, 1'b1, q_cnt_r <= QCNT_W'(QUEUE_DEPTH),
    "queue count above depth")
  `SAWARQ_ASSERT_NOW(a_empty_idle, q_cnt_r == '0, !outstanding_r,
    "packet outstanding with empty queue")
  `SAWARQ_ASSERT_NOW(a_send_outst, state_r == S_SEND, outstanding_r && (q_cnt_r != '0),
    "send without an outstanding queued packet")
  `SAWARQ_ASSERT_NEXT(a_timeout_send,
    in_acc && (in_word.cmd == CMD_TICK) && outstanding_r && (timer_r <= TMR_W'(1)),
    (state_r == S_SEND) && retx_r, "timer expiry did not start a retransmission")

endmodule
